/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the tokenizer core. Each use
// expects clk and rst_n to be visible in the module that expands it.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define AST_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the same cycle whenever a trigger is seen.
`define AST_ASSERT_IMPL(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

/* rtl/core/ast_pkg.sv */
// ----------------------------------------------------------------------------
// Assembly source tokenizer package
// Shared widths, token encodings, result record layout and queue sizing.
// ----------------------------------------------------------------------------
package ast_pkg;

    // Width of the line and column counters; they saturate at all ones.
    localparam int COUNTER_BITS = 16;

    // Width of the line and column fields carried in a result.
    localparam int POS_W = 16;

    // Most results that one source byte can cause.
    localparam int RES_MAX   = 3;
    localparam int RES_CNT_W = $clog2(RES_MAX + 1);

    // Result queue sizing.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Result kinds.
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Token type codes.
    localparam logic [2:0] TOK_INSTR  = 3'd0;
    localparam logic [2:0] TOK_IDENT  = 3'd1;
    localparam logic [2:0] TOK_NUMBER = 3'd2;
    localparam logic [2:0] TOK_STRING = 3'd3;
    localparam logic [2:0] TOK_OPER   = 3'd4;

    // Lexer mode, one-hot.
    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_COMMENT = 6'b000010,
        MODE_INSTR   = 6'b000100,
        MODE_IDENT   = 6'b001000,
        MODE_NUMBER  = 6'b010000,
        MODE_STRING  = 6'b100000
    } mode_t;

    // One result record.
    typedef struct packed {
        logic               kind;
        logic [2:0]         token_type;
        logic [7:0]         text_char;
        logic [POS_W-1:0]   line_number;
        logic [POS_W-1:0]   column;
        logic signed [31:0] number_value;
        logic               number_error;
        logic               last;
    } result_t;

    // All results of one processed byte, handed to the result queue.
    typedef struct packed {
        logic                          valid;
        logic [RES_CNT_W-1:0]          count;
        result_t [RES_MAX-1:0]         res;
    } batch_t;

endpackage

/* rtl/core/ast_intf.sv */
// ----------------------------------------------------------------------------
// Tokenizer channel interfaces
// Valid/ready channels for the source byte input and the result output.
// ----------------------------------------------------------------------------

// Source text channel: one byte per beat.
interface ast_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_text;

    modport source (output valid, output source_byte, output end_of_text, input ready);
    modport sink   (input valid, input source_byte, input end_of_text, output ready);
endinterface

// Token result channel: one text character or token-end record per beat.
interface ast_token_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [2:0]         token_type;
    logic [7:0]         text_char;
    logic [15:0]        line_number;
    logic [15:0]        column;
    logic signed [31:0] number_value;
    logic               number_error;
    logic               last;

    modport source (
        output valid, output kind, output token_type, output text_char,
        output line_number, output column, output number_value,
        output number_error, output last, input ready
    );
    modport sink (
        input valid, input kind, input token_type, input text_char,
        input line_number, input column, input number_value,
        input number_error, input last, output ready
    );
endinterface

/* rtl/core/assembly_source_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// Assembly source tokenizer
// Splits a stream of source bytes into token characters and token-end
// records with line, column and number value.
//
//   Channel   Dir   Beat carries
//   text      in    source_byte, end_of_text
//   tokens    out   kind, token_type, text_char, line_number, column,
//                   number_value, number_error, last
//
// A byte is taken into an input register, then processed combinationally:
// its zero to three results enter a four-entry result queue together.
// A byte with at most one result sustains one byte per cycle while the queue
// has room; a byte with n results holds the input until the queue has n free
// entries, so the rate follows the token channel at one result per beat.
// Reset clears the lexer state and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_top (
    input  logic        clk,
    input  logic        rst_n,
    ast_text_if.sink    text,
    ast_token_if.source tokens
);

    ast_pkg::batch_t                 batch;
    logic [ast_pkg::FIFO_CNT_W-1:0]  free;

    // Input register, lexer state and per-byte step.
    ast_lexer u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .free  (free),
        .batch (batch)
    );

    // Result queue toward the token channel.
    ast_result_fifo u_result_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .batch  (batch),
        .free   (free),
        .tokens (tokens)
    );

endmodule

/* rtl/core/ast_lexer.sv */
// ----------------------------------------------------------------------------
// Tokenizer lexer stage
// Input register, lexer state and the combinational step that turns one
// registered byte into up to three result records.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ast_lexer (
    input  logic                           clk,
    input  logic                           rst_n,
    ast_text_if.sink                       text,
    input  logic [ast_pkg::FIFO_CNT_W-1:0] free,
    output ast_pkg::batch_t                batch
);

    localparam int CB = ast_pkg::COUNTER_BITS;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG9   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    // Saturating counter increment.
    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        sat_inc = (v == {CB{1'b1}}) ? v : v + CB'(1);
    endfunction

    // Token type reported for a token mode.
    function automatic logic [2:0] type_of(input ast_pkg::mode_t m);
        case (m)
            ast_pkg::MODE_INSTR:  type_of = ast_pkg::TOK_INSTR;
            ast_pkg::MODE_IDENT:  type_of = ast_pkg::TOK_IDENT;
            ast_pkg::MODE_NUMBER: type_of = ast_pkg::TOK_NUMBER;
            ast_pkg::MODE_STRING: type_of = ast_pkg::TOK_STRING;
            default:              type_of = ast_pkg::TOK_INSTR;
        endcase
    endfunction

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eot_reg;

    // Lexer state.
    ast_pkg::mode_t mode_reg, mode_next;
    logic           esc_reg, esc_next;
    logic [CB-1:0]  line_reg, line_next;
    logic [CB-1:0]  colc_reg, colc_next;
    logic [CB-1:0]  tokc_reg, tokc_next;
    logic [31:0]    acc_reg, acc_next;
    logic           seen_reg, seen_next;
    logic           over_reg, over_next;

    // Step decode.
    logic [7:0]     c;
    logic           quoted;
    logic           do_end;
    logic           do_app;
    logic           do_op;
    logic [7:0]     app_char;
    ast_pkg::mode_t app_mode;
    ast_pkg::mode_t open_mode;
    logic           digit;
    logic [31:0]    acc_times10;

    // Result assembly.
    logic                            end_v;
    logic                            chr_v;
    ast_pkg::result_t                end_rec;
    ast_pkg::result_t                chr_rec;
    ast_pkg::result_t                op_rec;
    logic [ast_pkg::RES_CNT_W-1:0]   count;
    logic                            fire;

    assign c           = in_byte_reg;
    assign quoted      = (mode_reg == ast_pkg::MODE_COMMENT) || (mode_reg == ast_pkg::MODE_STRING);
    assign digit       = (c >= CH_DIG0) && (c <= CH_DIG9);
    assign acc_times10 = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};

    // Next lexer state for the registered byte.
    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        line_next = line_reg;
        colc_next = colc_reg;
        tokc_next = tokc_reg;
        acc_next  = acc_reg;
        seen_next = seen_reg;
        over_next = over_reg;
        do_end    = 1'b0;
        do_app    = 1'b0;
        do_op     = 1'b0;
        app_char  = c;
        app_mode  = mode_reg;
        open_mode = ast_pkg::MODE_IDLE;

        if (in_eot_reg)
        begin
            do_end    = 1'b1;
            esc_next  = 1'b0;
            line_next = CB'(1);
            colc_next = '0;
            tokc_next = '0;
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            case (c)
                CH_DIG0:
                begin
                    do_app   = 1'b1;
                    app_char = CH_NUL;
                end
                CH_LOW_N:
                begin
                    do_app   = 1'b1;
                    app_char = CH_LF;
                end
                CH_LOW_R:
                begin
                    do_app   = 1'b1;
                    app_char = CH_CR;
                end
                CH_LOW_T:
                begin
                    do_app   = 1'b1;
                    app_char = CH_TAB;
                end
                CH_QUOTE:
                begin
                    do_app   = 1'b1;
                    app_char = CH_QUOTE;
                end
                default:
                begin
                    do_app = 1'b0;
                end
            endcase
        end
        else
        begin
            case (c)
                CH_HASH:
                begin
                    if (quoted)
                    begin
                        do_app = 1'b1;
                    end
                    else
                    begin
                        do_end    = 1'b1;
                        open_mode = ast_pkg::MODE_NUMBER;
                    end
                end
                CH_BSLASH:
                begin
                    if (mode_reg == ast_pkg::MODE_STRING)
                    begin
                        esc_next = 1'b1;
                    end
                end
                CH_QUOTE:
                begin
                    if (mode_reg == ast_pkg::MODE_COMMENT)
                    begin
                        do_app = 1'b1;
                    end
                    else if (mode_reg == ast_pkg::MODE_STRING)
                    begin
                        do_end = 1'b1;
                    end
                    else
                    begin
                        do_end    = 1'b1;
                        open_mode = ast_pkg::MODE_STRING;
                    end
                end
                CH_LF, CH_CR:
                begin
                    do_end    = 1'b1;
                    colc_next = '0;
                    line_next = sat_inc(line_reg);
                end
                CH_SPACE:
                begin
                    if (quoted)
                    begin
                        do_app = 1'b1;
                    end
                    else
                    begin
                        do_end = 1'b1;
                    end
                end
                CH_SEMI:
                begin
                    if (quoted)
                    begin
                        do_app = 1'b1;
                    end
                    else
                    begin
                        do_end    = 1'b1;
                        open_mode = ast_pkg::MODE_COMMENT;
                    end
                end
                CH_COLON, CH_COMMA, CH_AT, CH_PCT, CH_SLASH,
                CH_STAR, CH_MINUS, CH_PLUS, CH_RBRACK, CH_LBRACK:
                begin
                    if (quoted)
                    begin
                        do_app = 1'b1;
                    end
                    else
                    begin
                        do_end = 1'b1;
                        do_op  = 1'b1;
                    end
                end
                CH_TAB:
                begin
                    do_app = 1'b0;
                end
                default:
                begin
                    // Ordinary character: opens a word or extends the open token.
                    if (mode_reg == ast_pkg::MODE_IDLE)
                    begin
                        mode_next = (colc_reg == '0) ? ast_pkg::MODE_INSTR
                                                     : ast_pkg::MODE_IDENT;
                        tokc_next = colc_reg;
                    end
                    else
                    begin
                        if ((mode_reg == ast_pkg::MODE_NUMBER) && !over_reg)
                        begin
                            if (digit)
                            begin
                                acc_next  = acc_times10 + {28'b0, c[3:0]};
                                seen_next = 1'b1;
                            end
                            else if (!seen_reg && ((c == CH_VT) || (c == CH_FF)))
                            begin
                                over_next = 1'b0;
                            end
                            else
                            begin
                                over_next = 1'b1;
                            end
                        end
                        tokc_next = sat_inc(colc_reg);
                    end
                    do_app    = 1'b1;
                    app_mode  = mode_next;
                    colc_next = sat_inc(colc_reg);
                end
            endcase
        end

        // Closing the open token clears the number state before any new mode.
        if (do_end)
        begin
            mode_next = open_mode;
            acc_next  = '0;
            seen_next = 1'b0;
            over_next = 1'b0;
        end
    end

    // Result records in emission order: token end, character, operator end.
    always_comb
    begin
        end_v = do_end && ((mode_reg == ast_pkg::MODE_INSTR) || (mode_reg == ast_pkg::MODE_IDENT)
                || (mode_reg == ast_pkg::MODE_NUMBER) || (mode_reg == ast_pkg::MODE_STRING));
        chr_v = do_op || (do_app && ((app_mode == ast_pkg::MODE_INSTR)
                || (app_mode == ast_pkg::MODE_IDENT) || (app_mode == ast_pkg::MODE_NUMBER)
                || (app_mode == ast_pkg::MODE_STRING)));

        end_rec.kind         = ast_pkg::KIND_END;
        end_rec.token_type   = type_of(mode_reg);
        end_rec.text_char    = CH_NUL;
        end_rec.line_number  = ast_pkg::POS_W'(line_reg);
        end_rec.column       = ast_pkg::POS_W'(tokc_reg);
        end_rec.number_value = ((mode_reg == ast_pkg::MODE_NUMBER) && seen_reg) ? acc_reg : '0;
        end_rec.number_error = (mode_reg == ast_pkg::MODE_NUMBER) && !seen_reg;
        end_rec.last         = 1'b0;

        chr_rec.kind         = ast_pkg::KIND_TEXT;
        chr_rec.token_type   = do_op ? ast_pkg::TOK_OPER : type_of(app_mode);
        chr_rec.text_char    = app_char;
        chr_rec.line_number  = ast_pkg::POS_W'(line_reg);
        chr_rec.column       = ast_pkg::POS_W'(tokc_next);
        chr_rec.number_value = '0;
        chr_rec.number_error = 1'b0;
        chr_rec.last         = 1'b0;

        op_rec.kind          = ast_pkg::KIND_END;
        op_rec.token_type    = ast_pkg::TOK_OPER;
        op_rec.text_char     = CH_NUL;
        op_rec.line_number   = ast_pkg::POS_W'(line_reg);
        op_rec.column        = ast_pkg::POS_W'(tokc_reg);
        op_rec.number_value  = '0;
        op_rec.number_error  = 1'b0;
        op_rec.last          = 1'b0;

        count = ast_pkg::RES_CNT_W'(end_v) + ast_pkg::RES_CNT_W'(chr_v)
              + ast_pkg::RES_CNT_W'(do_op);

        batch.res[0] = end_v ? end_rec : chr_rec;
        batch.res[1] = end_v ? chr_rec : op_rec;
        batch.res[2] = op_rec;
        for (int i = 0; i < ast_pkg::RES_MAX; i++)
        begin
            batch.res[i].last = (ast_pkg::RES_CNT_W'(i + 1) == count);
        end
        batch.count = count;
        batch.valid = fire;
    end

    // The registered byte is processed once the queue has room for its results.
    assign fire       = in_valid_reg && (ast_pkg::FIFO_CNT_W'(count) <= free);
    assign text.ready = !in_valid_reg || fire;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text.valid && text.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_byte_reg <= text.source_byte;
            in_eot_reg  <= text.end_of_text;
        end
    end

    // Lexer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ast_pkg::MODE_IDLE;
            esc_reg  <= 1'b0;
            line_reg <= CB'(1);
            colc_reg <= '0;
            tokc_reg <= '0;
            acc_reg  <= '0;
            seen_reg <= 1'b0;
            over_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            line_reg <= line_next;
            colc_reg <= colc_next;
            tokc_reg <= tokc_next;
            acc_reg  <= acc_next;
            seen_reg <= seen_next;
            over_reg <= over_next;
        end
    end

    `AST_ASSERT_IMPL(a_esc_only_in_string, esc_reg, mode_reg == ast_pkg::MODE_STRING, "escape pending outside a string")
    `AST_ASSERT_IMPL(a_number_state_in_number, seen_reg || over_reg || (acc_reg != '0), mode_reg == ast_pkg::MODE_NUMBER, "number state left over outside a number token")
    `AST_ASSERT(a_line_nonzero, line_reg != '0, "line counter reached zero")

endmodule

/* rtl/core/ast_result_fifo.sv */
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Takes the up to three results of one byte at once and hands
// them out one per beat on the token channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ast_result_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ast_pkg::batch_t                 batch,
    output logic [ast_pkg::FIFO_CNT_W-1:0]  free,
    ast_token_if.source                     tokens
);

    localparam int DEPTH = ast_pkg::FIFO_DEPTH;
    localparam int PW    = ast_pkg::FIFO_PTR_W;
    localparam int CW    = ast_pkg::FIFO_CNT_W;

    ast_pkg::result_t mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;

    logic                            pop;
    logic [ast_pkg::RES_CNT_W-1:0]   push_n;
    logic [PW-1:0]                   wr_off [DEPTH];
    logic [DEPTH-1:0]                wr_en;
    ast_pkg::result_t                head;

    assign pop    = tokens.valid && tokens.ready;
    assign push_n = batch.valid ? batch.count : '0;
    assign free   = CW'(DEPTH) - cnt_reg + CW'(pop);

    // Each entry decides on its own which result of the batch it takes.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            wr_off[i] = PW'(i) - wr_ptr_reg;
            wr_en[i]  = batch.valid && (CW'(wr_off[i]) < CW'(batch.count));
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (wr_en[i])
            begin
                mem_reg[i] <= batch.res[wr_off[i]];
            end
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PW'(pop);
            cnt_reg    <= cnt_reg + CW'(push_n) - CW'(pop);
        end
    end

    // Head of the queue drives the channel.
    assign head                = mem_reg[rd_ptr_reg];
    assign tokens.valid        = (cnt_reg != '0);
    assign tokens.kind         = head.kind;
    assign tokens.token_type   = head.token_type;
    assign tokens.text_char    = head.text_char;
    assign tokens.line_number  = head.line_number;
    assign tokens.column       = head.column;
    assign tokens.number_value = head.number_value;
    assign tokens.number_error = head.number_error;
    assign tokens.last         = head.last;

    `AST_ASSERT(a_fill_bounded, cnt_reg <= CW'(DEPTH), "result queue overfilled")

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Assembly source tokenizer testbench
// Feeds source bytes over the text channel and checks every token beat
// against a cycle-free model of the lexer kept in this file. A short table
// of directed bytes covers escapes, numbers, comments and end of text; a
// random part then sends whole source lines with random content mixed with
// raw noise. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int RAND_ITEMS   = 350;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_MAX   = 10;
    localparam int CB           = ast_pkg::COUNTER_BITS;
    localparam int PW           = ast_pkg::POS_W;

    // Characters with a special meaning to the lexer.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [7:0] OPER_CHARS [10] = '{":", ",", "@", "%", "/", "*", "-", "+", "[", "]"};
    localparam logic [7:0] ESC_CHARS [5]   = '{"0", "n", "r", "t", CH_QUOTE};

    typedef struct {
        logic [7:0]       code;
        logic             eot;
        int               reps;
        bit               pinned;
        ast_pkg::result_t want;
    } src_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ast_text_if  txt ();
    ast_token_if tok ();

    assembly_source_tokenizer_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (txt),
        .tokens (tok)
    );

    // Lexer model state.
    ast_pkg::mode_t lx_mode;
    logic           lx_escape;
    logic [CB-1:0]  lx_line;
    logic [CB-1:0]  lx_col;
    logic [CB-1:0]  lx_tok_col;
    logic [31:0]    lx_value;
    logic           lx_have_digit;
    logic           lx_digits_done;

    // Results of the byte the model last consumed.
    ast_pkg::result_t lex_out [ast_pkg::RES_MAX];
    int               lex_n;

    ast_pkg::result_t tok_expect_q [$];
    src_row_t         dir_rows [$];
    src_row_t         rand_rows [$];

    bit quiet;
    int errors;
    int bytes_sent;
    int results_seen;
    int records_seen;
    int cycle_count;

    // Clock generation.
    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------------

    function automatic logic [CB-1:0] bump_sat(logic [CB-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [2:0] mode_tok(ast_pkg::mode_t m);
        case (m)
            ast_pkg::MODE_INSTR:  return ast_pkg::TOK_INSTR;
            ast_pkg::MODE_IDENT:  return ast_pkg::TOK_IDENT;
            ast_pkg::MODE_NUMBER: return ast_pkg::TOK_NUMBER;
            ast_pkg::MODE_STRING: return ast_pkg::TOK_STRING;
            default:              return ast_pkg::TOK_OPER;
        endcase
    endfunction

    function automatic bit builds_text(ast_pkg::mode_t m);
        return m inside {ast_pkg::MODE_INSTR, ast_pkg::MODE_IDENT,
                         ast_pkg::MODE_NUMBER, ast_pkg::MODE_STRING};
    endfunction

    function automatic void lex_reset();
        lx_mode        = ast_pkg::MODE_IDLE;
        lx_escape      = 1'b0;
        lx_line        = CB'(1);
        lx_col         = '0;
        lx_tok_col     = '0;
        lx_value       = '0;
        lx_have_digit  = 1'b0;
        lx_digits_done = 1'b0;
    endfunction

    // A byte never yields more than three results; extras are dropped.
    function automatic void queue_result(logic kind, logic [2:0] ttype, logic [7:0] ch,
                                         logic [31:0] val, logic err);
        ast_pkg::result_t r;
        if (lex_n < ast_pkg::RES_MAX)
        begin
            r.kind         = kind;
            r.token_type   = ttype;
            r.text_char    = ch;
            r.line_number  = PW'(lx_line);
            r.column       = PW'(lx_tok_col);
            r.number_value = val;
            r.number_error = err;
            r.last         = 1'b0;
            lex_out[lex_n] = r;
            lex_n++;
        end
    endfunction

    function automatic void add_text(logic [7:0] ch);
        if (builds_text(lx_mode))
            queue_result(ast_pkg::KIND_TEXT, mode_tok(lx_mode), ch, '0, 1'b0);
    endfunction

    // Only the leading digit run counts; VT and FF before it are skipped.
    function automatic void take_digit(logic [7:0] c);
        if (!lx_digits_done)
        begin
            if (c >= "0" && c <= "9")
            begin
                lx_value      = lx_value * 32'd10 + 32'(c - 8'h30);
                lx_have_digit = 1'b1;
            end
            else if (!lx_have_digit && (c == CH_VT || c == CH_FF))
            begin
            end
            else
                lx_digits_done = 1'b1;
        end
    endfunction

    function automatic void close_token();
        if (builds_text(lx_mode))
        begin
            if (lx_mode == ast_pkg::MODE_NUMBER)
            begin
                if (lx_have_digit)
                    queue_result(ast_pkg::KIND_END, ast_pkg::TOK_NUMBER, CH_NUL, lx_value, 1'b0);
                else
                    queue_result(ast_pkg::KIND_END, ast_pkg::TOK_NUMBER, CH_NUL, '0, 1'b1);
            end
            else
                queue_result(ast_pkg::KIND_END, mode_tok(lx_mode), CH_NUL, '0, 1'b0);
        end
        lx_mode        = ast_pkg::MODE_IDLE;
        lx_value       = '0;
        lx_have_digit  = 1'b0;
        lx_digits_done = 1'b0;
    endfunction

    // Consume one input beat and leave its results in lex_out.
    function automatic void lex_byte(logic [7:0] c, logic eot);
        bit quoted;
        lex_n  = 0;
        quoted = (lx_mode == ast_pkg::MODE_COMMENT) || (lx_mode == ast_pkg::MODE_STRING);
        if (eot)
        begin
            close_token();
            lex_reset();
        end
        else if (lx_escape)
        begin
            // The byte after a backslash in a string; unknown escapes vanish.
            lx_escape = 1'b0;
            case (c)
                "0":      add_text(CH_NUL);
                "n":      add_text(CH_LF);
                "r":      add_text(CH_CR);
                "t":      add_text(CH_TAB);
                CH_QUOTE: add_text(CH_QUOTE);
                default:  ;
            endcase
        end
        else
        begin
            case (c)
                CH_HASH:
                    if (quoted)
                        add_text(c);
                    else
                    begin
                        close_token();
                        lx_mode = ast_pkg::MODE_NUMBER;
                    end
                CH_BSLASH:
                    if (lx_mode == ast_pkg::MODE_STRING)
                        lx_escape = 1'b1;
                CH_QUOTE:
                    if (lx_mode == ast_pkg::MODE_COMMENT)
                        add_text(c);
                    else if (lx_mode == ast_pkg::MODE_STRING)
                        close_token();
                    else
                    begin
                        close_token();
                        lx_mode = ast_pkg::MODE_STRING;
                    end
                CH_LF, CH_CR:
                begin
                    close_token();
                    lx_col  = '0;
                    lx_line = bump_sat(lx_line);
                end
                CH_SPACE:
                    if (quoted)
                        add_text(c);
                    else
                        close_token();
                CH_SEMI:
                    if (quoted)
                        add_text(c);
                    else
                    begin
                        close_token();
                        lx_mode = ast_pkg::MODE_COMMENT;
                    end
                ":", ",", "@", "%", "/", "*", "-", "+", "]", "[":
                    if (quoted)
                        add_text(c);
                    else
                    begin
                        close_token();
                        queue_result(ast_pkg::KIND_TEXT, ast_pkg::TOK_OPER, c, '0, 1'b0);
                        queue_result(ast_pkg::KIND_END, ast_pkg::TOK_OPER, CH_NUL, '0, 1'b0);
                    end
                CH_TAB:
                    ;
                default:
                begin
                    // A word at column zero is an instruction.
                    if (lx_mode == ast_pkg::MODE_IDLE)
                    begin
                        lx_mode    = (lx_col == '0) ? ast_pkg::MODE_INSTR
                                                    : ast_pkg::MODE_IDENT;
                        lx_tok_col = lx_col;
                    end
                    else
                    begin
                        if (lx_mode == ast_pkg::MODE_NUMBER)
                            take_digit(c);
                        lx_tok_col = bump_sat(lx_col);
                    end
                    add_text(c);
                    lx_col = bump_sat(lx_col);
                end
            endcase
        end
        if (lex_n > 0)
            lex_out[lex_n-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic ast_pkg::result_t pin_res(logic kind, logic [2:0] ttype,
                                                 logic [7:0] ch, int line, int col,
                                                 logic err);
        ast_pkg::result_t r;
        r.kind         = kind;
        r.token_type   = ttype;
        r.text_char    = ch;
        r.line_number  = PW'(line);
        r.column       = PW'(col);
        r.number_value = '0;
        r.number_error = err;
        r.last         = 1'b1;
        return r;
    endfunction

    function automatic void table_row(logic [7:0] code, logic eot, int reps = 1,
                                      bit pinned = 1'b0, ast_pkg::result_t want = '0);
        src_row_t row;
        row.code   = code;
        row.eot    = eot;
        row.reps   = reps;
        row.pinned = pinned;
        row.want   = want;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void put(logic [7:0] code, logic eot = 1'b0);
        src_row_t row;
        row.code   = code;
        row.eot    = eot;
        row.reps   = 1;
        row.pinned = 1'b0;
        row.want   = '0;
        rand_rows.insert(rand_rows.size(), row);
    endfunction

    function automatic void put_word(int len);
        int r;
        repeat (len)
        begin
            r = int'($urandom_range(0, 63));
            if (r < 26)
                put(8'("a" + r));
            else if (r < 52)
                put(8'("A" + r - 26));
            else if (r < 62)
                put(8'("0" + r - 52));
            else
                put("_");
        end
    endfunction

    // Mostly short numbers, some long enough to wrap, a few without digits.
    function automatic void put_number();
        int digits;
        int r;
        put(CH_HASH);
        if ($urandom_range(0, 9) == 0)
            put($urandom_range(0, 1) ? CH_VT : CH_FF);
        r = int'($urandom_range(0, 19));
        if (r == 0)
            digits = 0;
        else if (r < 3)
            digits = int'($urandom_range(9, 12));
        else
            digits = int'($urandom_range(1, 4));
        repeat (digits)
            put(8'(8'h30 + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0)
            put_word(int'($urandom_range(1, 2)));
    endfunction

    // Mostly source lines of random content, the rest raw noise bytes.
    function automatic void make_random_text(int target);
        int ops;
        int r;
        while (rand_rows.size() < target)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                repeat ($urandom_range(1, 8))
                    put(8'($urandom_range(0, 255)));
            end
            else
            begin
                put_word(int'($urandom_range(1, 6)));
                ops = int'($urandom_range(0, 3));
                for (int k = 0; k < ops; k++)
                begin
                    if (k > 0 && $urandom_range(0, 1))
                        put(",");
                    put($urandom_range(0, 7) == 0 ? CH_TAB : CH_SPACE);
                    case ($urandom_range(0, 5))
                        0: put_word(int'($urandom_range(1, 8)));
                        1: put_number();
                        2:
                        begin
                            put(CH_QUOTE);
                            repeat ($urandom_range(0, 6))
                            begin
                                r = int'($urandom_range(0, 9));
                                if (r < 2)
                                begin
                                    put(CH_BSLASH);
                                    if (r == 0)
                                        put(ESC_CHARS[$urandom_range(0, 4)]);
                                    else
                                        put(8'($urandom_range(0, 255)));
                                end
                                else
                                    put(8'($urandom_range(32, 126)));
                            end
                            if ($urandom_range(0, 9) != 0)
                                put(CH_QUOTE);
                        end
                        3:
                        begin
                            put("[");
                            put_word(int'($urandom_range(1, 3)));
                            put($urandom_range(0, 1) ? "+" : "-");
                            put_number();
                            put("]");
                        end
                        4:
                        begin
                            put("%");
                            put_word(int'($urandom_range(1, 3)));
                        end
                        default: put(OPER_CHARS[$urandom_range(0, 9)]);
                    endcase
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    put(CH_SPACE);
                    put(CH_SEMI);
                    repeat ($urandom_range(0, 6))
                        put(8'($urandom_range(32, 126)));
                end
            end
            // Line end: LF, CR, CR LF, or now and then the end of text.
            r = int'($urandom_range(0, 19));
            if (r < 12)
                put(CH_LF);
            else if (r < 15)
                put(CH_CR);
            else if (r < 18)
            begin
                put(CH_CR);
                put(CH_LF);
            end
            else
                put(8'($urandom_range(0, 255)), 1'b1);
        end
    endfunction

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            return 0;
        if (r < 85)
            return int'($urandom_range(1, 3));
        if (r < 97)
            return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 40));
    endfunction

    function automatic string fmt_res(ast_pkg::result_t r);
        return $sformatf("kind=%0d type=%0d char=%02h line=%0d col=%0d value=%0d err=%0b last=%0b",
                         r.kind, r.token_type, r.text_char, r.line_number, r.column,
                         r.number_value, r.number_error, r.last);
    endfunction

    // Send one beat after a random gap and record what it should produce.
    task automatic send_byte(logic [7:0] code, logic eot, bit pinned, ast_pkg::result_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            txt.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        txt.valid       <= 1'b1;
        txt.source_byte <= code;
        txt.end_of_text <= eot;
        do
            @(posedge clk);
        while (txt.ready !== 1'b1);
        lex_byte(code, eot);
        if (pinned)
            tok_expect_q.insert(tok_expect_q.size(), want);
        else
            for (int i = 0; i < lex_n; i++)
                tok_expect_q.insert(tok_expect_q.size(), lex_out[i]);
        bytes_sent++;
    endtask

    // Stop sending until every expected beat has come out.
    task automatic hold_until_drained();
        txt.valid <= 1'b0;
        do
            @(posedge clk);
        while (tok_expect_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls on ready.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        tok.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                tok.ready <= 1'b0;
            end
            else
            begin
                tok.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Compare each accepted token beat with the oldest expectation.
    always @(posedge clk)
    begin
        ast_pkg::result_t got;
        ast_pkg::result_t want;
        if (rst_n === 1'b1 && tok.valid === 1'b1 && tok.ready === 1'b1)
        begin
            got.kind         = tok.kind;
            got.token_type   = tok.token_type;
            got.text_char    = tok.text_char;
            got.line_number  = tok.line_number;
            got.column       = tok.column;
            got.number_value = tok.number_value;
            got.number_error = tok.number_error;
            got.last         = tok.last;
            if (tok_expect_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected token beat: %s", fmt_res(got));
            end
            else
            begin
                want = tok_expect_q.pop_front();
                results_seen++;
                if (want.kind == ast_pkg::KIND_END)
                    records_seen++;
                if (got !== want)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                    begin
                        $display("token beat mismatch at beat %0d", results_seen);
                        $display("  expected %s", fmt_res(want));
                        $display("  actual   %s", fmt_res(got));
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           <= 1'b0;
        txt.valid       <= 1'b0;
        txt.source_byte <= CH_NUL;
        txt.end_of_text <= 1'b0;
        quiet        = 1'b0;
        errors       = 0;
        bytes_sent   = 0;
        results_seen = 0;
        records_seen = 0;
        cycle_count  = 0;
        lex_reset();

        // Directed table: instruction, number with skipped VT, operator.
        table_row("m", 1'b0, 1, 1'b1,
                  pin_res(ast_pkg::KIND_TEXT, ast_pkg::TOK_INSTR, "m", 1, 0, 1'b0));
        table_row(CH_SPACE, 1'b0, 1, 1'b1,
                  pin_res(ast_pkg::KIND_END, ast_pkg::TOK_INSTR, CH_NUL, 1, 0, 1'b0));
        table_row(CH_HASH, 1'b0);
        table_row(CH_VT, 1'b0);
        table_row("4", 1'b0);
        table_row("2", 1'b0);
        table_row(",", 1'b0);
        // Number without digits.
        table_row(CH_HASH, 1'b0);
        table_row(CH_SPACE, 1'b0, 1, 1'b1,
                  pin_res(ast_pkg::KIND_END, ast_pkg::TOK_NUMBER, CH_NUL, 1, 4, 1'b1));
        // String with a mapped escape, a dropped escape and byte extremes.
        table_row(CH_QUOTE, 1'b0);
        table_row(CH_BSLASH, 1'b0);
        table_row("n", 1'b0);
        table_row(CH_BSLASH, 1'b0);
        table_row("q", 1'b0);
        table_row(8'hFF, 1'b0);
        table_row(CH_NUL, 1'b0);
        table_row(CH_TAB, 1'b0);
        table_row(CH_QUOTE, 1'b0);
        // Comment holding a backslash, then two line ends.
        table_row(CH_SEMI, 1'b0);
        table_row(CH_BSLASH, 1'b0);
        table_row(CH_LF, 1'b0);
        table_row(CH_CR, 1'b0);
        table_row("a", 1'b0, 1, 1'b1,
                  pin_res(ast_pkg::KIND_TEXT, ast_pkg::TOK_INSTR, "a", 3, 0, 1'b0));
        table_row(CH_NUL, 1'b1, 1, 1'b1,
                  pin_res(ast_pkg::KIND_END, ast_pkg::TOK_INSTR, CH_NUL, 3, 0, 1'b0));
        // End of text while an escape is pending.
        table_row(CH_QUOTE, 1'b0);
        table_row(CH_BSLASH, 1'b0);
        table_row(CH_NUL, 1'b1, 1, 1'b1,
                  pin_res(ast_pkg::KIND_END, ast_pkg::TOK_STRING, CH_NUL, 1, 0, 1'b0));

        make_random_text(RAND_ITEMS);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part; long repeats run without idling.
        foreach (dir_rows[i])
        begin
            quiet = dir_rows[i].reps > 1;
            repeat (dir_rows[i].reps)
                send_byte(dir_rows[i].code, dir_rows[i].eot, dir_rows[i].pinned,
                          dir_rows[i].want);
        end
        quiet = 1'b0;
        hold_until_drained();

        // Random part, with a pause halfway and one stretch without idling.
        foreach (rand_rows[i])
        begin
            if (i == rand_rows.size() / 2)
                hold_until_drained();
            quiet = (i >= rand_rows.size() / 4) && (i < rand_rows.size() / 4 + 40);
            send_byte(rand_rows[i].code, rand_rows[i].eot, 1'b0, rand_rows[i].want);
        end
        quiet = 1'b0;

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d source beats (%0d directed rows, %0d random), checked %0d token beats",
                 bytes_sent, dir_rows.size(), rand_rows.size(), results_seen);
        $display("of which %0d were token-end records; %0d mismatches.", records_seen, errors);
        if (errors == 0 && tok_expect_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ast_pkg.sv
rtl/core/ast_intf.sv
rtl/core/ast_lexer.sv
rtl/core/ast_result_fifo.sv
rtl/core/assembly_source_tokenizer_top.sv
bench/tb.sv
